// ===== src/rsq_pkg.sv =====
// rsq_pkg: shared constants, codes and control/status structs of the packet resequencer
// no dependencies

package rsq_pkg;

  localparam int RSQ_WINDOW        = 16;
  localparam int MAX_RESULTS       = 17;
  localparam int RUN_W             = $clog2(MAX_RESULTS + 1);
  localparam int SEQ_W             = 16;
  localparam int TAG_W             = 16;
  localparam int KIND_W            = 2;
  localparam int ERR_W             = 4;
  localparam logic [ERR_W-1:0] ERROR_LIMIT_RESET = 4'd5;
  localparam logic [ERR_W-1:0] ERROR_COUNT_MAX   = 4'd15;

  localparam logic [KIND_W-1:0] KIND_PKT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERR    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BADLEN = 2'd2;

  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_ENDED   = 1'b1;

  typedef struct packed {
    logic latch_in;
    logic err_count;
    logic err_end;
    logic direct;
    logic park;
    logic run_clear;
    logic rd_issue;
    logic rd_deliver;
  } rsq_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ended;
    logic              err_end;
    logic              d_one;
    logic              d_park;
    logic              head_valid;
    logic              budget_ok;
    logic              more_direct;
    logic              more_drain;
    logic              out_free;
  } rsq_stat_t;

endpackage

// ===== src/rsq_ram.sv =====
// rsq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module rsq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rsq_ctrl.sv =====
// rsq_ctrl: sequencing state machine of the packet resequencer
// depends on rsq_pkg

module rsq_ctrl
  import rsq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rsq_stat_t stat,
  output rsq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          if (stat.ended) begin
            state_nxt = ST_IDLE;
          end else begin
            case (stat.kind)
              KIND_ERR: begin
                cmd.err_count = 1'b1;
                if (stat.err_end) begin
                  cmd.err_end = 1'b1;
                  state_nxt   = ST_IDLE;
                end else begin
                  cmd.run_clear = 1'b1;
                  state_nxt     = ST_CHECK;
                end
              end
              KIND_PKT: begin
                if (stat.d_one) begin
                  cmd.direct = 1'b1;
                  state_nxt  = stat.more_direct ? ST_CHECK : ST_IDLE;
                end else begin
                  cmd.park      = stat.d_park;
                  cmd.run_clear = 1'b1;
                  state_nxt     = ST_CHECK;
                end
              end
              default: begin
                cmd.run_clear = 1'b1;
                state_nxt     = ST_CHECK;
              end
            endcase
          end
        end
      end
      ST_CHECK: begin
        if (stat.head_valid && stat.budget_ok) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (stat.out_free) begin
          cmd.rd_deliver = 1'b1;
          state_nxt      = stat.more_drain ? ST_CHECK : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/rsq_dp.sv =====
// rsq_dp: datapath of the packet resequencer - item latch, window store, counters, output register
// depends on rsq_pkg and rsq_ram

module rsq_dp
  import rsq_pkg::*;
#(
  parameter int WINDOW = RSQ_WINDOW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [SEQ_W-1:0]  in_seq_number,
  input  logic [TAG_W-1:0]  in_payload_tag,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ERR_W-1:0]  cfg_error_limit,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_result_kind,
  output logic [TAG_W-1:0]  out_tag,
  output logic [SEQ_W-1:0]  out_seq,
  output logic              out_last_of_run,
  input  rsq_cmd_t          cmd,
  output rsq_stat_t         stat
);

  localparam int HW = $clog2(WINDOW);
  localparam logic [SEQ_W-1:0] D_MAX   = SEQ_W'(WINDOW - 1);
  localparam logic [HW:0]      W_EXT   = (HW+1)'(WINDOW);
  localparam logic [HW-1:0]    H_LAST  = HW'(WINDOW - 1);
  localparam logic [HW-1:0]    H_RESET = HW'(1 % WINDOW);

  logic [KIND_W-1:0] kind_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [TAG_W-1:0]  tag_r;
  logic [ERR_W-1:0]  limit_r;
  logic [ERR_W-1:0]  err_cnt_r;
  logic              ended_r;
  logic [SEQ_W-1:0]  last_del_r;
  logic [HW-1:0]     head_r;
  logic [WINDOW-1:0] valid_r, valid_nxt;
  logic [RUN_W-1:0]  run_r;
  logic              out_valid_r;
  logic              res_kind_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic              last_run_r;

  logic [SEQ_W-1:0]  seq_gap;
  logic [HW-1:0]     gap_m1;
  logic [HW:0]       slot_sum;
  logic [HW-1:0]     slot;
  logic [HW-1:0]     head_inc;
  logic [ERR_W-1:0]  err_sat;
  logic [TAG_W-1:0]  ram_rdata;
  logic              out_free;
  logic              deliver;
  logic              more_drain;

  assign cfg_ready = 1'b1;

  assign seq_gap  = seq_r - last_del_r;
  assign gap_m1   = seq_gap[HW-1:0] - HW'(1);
  assign slot_sum = {1'b0, head_r} + {1'b0, gap_m1};
  assign slot     = (slot_sum >= W_EXT) ? HW'(slot_sum - W_EXT) : slot_sum[HW-1:0];
  assign head_inc = (head_r == H_LAST) ? '0 : head_r + HW'(1);
  assign err_sat  = (err_cnt_r == ERROR_COUNT_MAX) ? err_cnt_r : err_cnt_r + ERR_W'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign deliver  = cmd.direct || cmd.rd_deliver;
  assign more_drain = valid_r[head_inc] && (run_r < RUN_W'(MAX_RESULTS - 1));

  assign stat.kind        = kind_r;
  assign stat.ended       = ended_r;
  assign stat.err_end     = (err_sat >= limit_r);
  assign stat.d_one       = (seq_gap == SEQ_W'(1));
  assign stat.d_park      = (seq_gap >= SEQ_W'(2)) && (seq_gap <= D_MAX);
  assign stat.head_valid  = valid_r[head_r];
  assign stat.budget_ok   = (run_r < RUN_W'(MAX_RESULTS));
  assign stat.more_direct = valid_r[head_inc];
  assign stat.more_drain  = more_drain;
  assign stat.out_free    = out_free;

  rsq_ram #(
    .WIDTH (TAG_W),
    .DEPTH (WINDOW)
  ) u_tag_ram (
    .clk   (clk),
    .we    (cmd.park),
    .waddr (slot),
    .wdata (tag_r),
    .re    (cmd.rd_issue),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.park) begin
      valid_nxt[slot] = 1'b1;
    end
    if (cmd.rd_deliver) begin
      valid_nxt[head_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      seq_r  <= in_seq_number;
      tag_r  <= in_payload_tag;
    end
    if (cmd.err_end) begin
      res_kind_r <= RES_ENDED;
      out_tag_r  <= '0;
      out_seq_r  <= '0;
      last_run_r <= 1'b1;
    end else if (deliver) begin
      res_kind_r <= RES_PAYLOAD;
      out_tag_r  <= cmd.direct ? tag_r : ram_rdata;
      out_seq_r  <= last_del_r + SEQ_W'(1);
      last_run_r <= cmd.direct ? !valid_r[head_inc] : !more_drain;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= ERROR_LIMIT_RESET;
      err_cnt_r   <= '0;
      ended_r     <= 1'b0;
      last_del_r  <= '0;
      head_r      <= H_RESET;
      valid_r     <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_error_limit;
      end
      if (cmd.err_count) begin
        err_cnt_r <= err_sat;
      end
      if (cmd.err_end) begin
        ended_r <= 1'b1;
      end
      if (deliver) begin
        last_del_r <= last_del_r + SEQ_W'(1);
        head_r     <= head_inc;
      end
      valid_r <= valid_nxt;
      if (cmd.run_clear) begin
        run_r <= '0;
      end else if (cmd.direct) begin
        run_r <= RUN_W'(1);
      end else if (cmd.rd_deliver) begin
        run_r <= run_r + RUN_W'(1);
      end
      if (cmd.err_end || deliver) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = res_kind_r;
  assign out_tag         = out_tag_r;
  assign out_seq         = out_seq_r;
  assign out_last_of_run = last_run_r;

endmodule

// ===== src/packet_resequencer.sv =====
// packet_resequencer: an in-order packet passes the item latch, then the output register once
// the output is free; each parked successor drained behind it takes a valid check, then a tag
// store read; one item is taken at a time, in_stall holding the next until this one is done
// reset - synchronous, clears counters, the call-ended flag and all window valid bits
// the tag store itself is not cleared
// depends on rsq_pkg, rsq_ctrl, rsq_dp and rsq_ram

module packet_resequencer
  import rsq_pkg::*;
#(
  parameter int WINDOW = RSQ_WINDOW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [SEQ_W-1:0]  in_seq_number,
  input  logic [TAG_W-1:0]  in_payload_tag,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ERR_W-1:0]  cfg_error_limit,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_result_kind,
  output logic [TAG_W-1:0]  out_tag,
  output logic [SEQ_W-1:0]  out_seq,
  output logic              out_last_of_run
);

  rsq_cmd_t  cmd;
  rsq_stat_t stat;

  rsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsq_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_seq_number   (in_seq_number),
    .in_payload_tag  (in_payload_tag),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_error_limit (cfg_error_limit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_tag         (out_tag),
    .out_seq         (out_seq),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

// ===== src/rsq_chk.sv =====
// rsq_chk: port-level checks on the packet resequencer, bound to the top level
// depends on rsq_pkg

module rsq_chk
  import rsq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_result_kind,
  input logic [TAG_W-1:0] out_tag,
  input logic [SEQ_W-1:0] out_seq,
  input logic             out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tag) && $stable(out_seq)
      && $stable(out_result_kind) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_ended_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RES_ENDED) |->
      (out_tag == '0) && (out_seq == '0) && out_last_of_run)
    else $error("call-ended result malformed");

  a_ended_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_result_kind == RES_ENDED) |=> !out_valid)
    else $error("result after call ended");

endmodule

bind packet_resequencer rsq_chk u_rsq_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_tag         (out_tag),
  .out_seq         (out_seq),
  .out_last_of_run (out_last_of_run)
);
